### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands; every user has i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the wildcard substring search block.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

    localparam logic [7:0] WILDCARD = 8'h3F;

    typedef enum logic [1:0] {
        ACT_PATTERN = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_EOL     = 2'd2,
        ACT_NEW     = 2'd3
    } t_action;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_CHECK = 1'b1
    } t_state;

    typedef struct packed {
        logic pat_push;
        logic text_push;
        logic text_drop;
        logic check;
        logic eol;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic text_room;
    } t_status;

endpackage

`default_nettype wire

### design/wss_dp.sv
// ----------------------------------------------------------------------------
// wss_dp
// Datapath: right-aligned pattern and text shift lines, parallel wildcard
// window compare, line and search bookkeeping, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wss_dp #(
    parameter int PATTERN_MAX = 64,
    parameter int LINE_MAX    = 128,
    parameter int ROWS_MAX    = 128
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wss_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]       i_data_byte,
    output wss_pkg::t_status      o_status,
    output logic                  o_line_found,
    output logic [6:0]            o_line_position,
    output logic                  o_search_found,
    output logic [7:0]            o_found_row,
    output logic                  o_line_overflow
);

    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int CW  = $clog2(LINE_MAX);
    localparam int RW  = $clog2(ROWS_MAX + 1);

    // newest byte at index PATTERN_MAX-1 in both lines
    logic [7:0]     r_pat [PATTERN_MAX];
    logic [7:0]     r_win [PATTERN_MAX];

    logic [PLW-1:0] r_plen;
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_line_hit;
    logic [CW-1:0]  r_hit_col;
    logic           r_search_hit;
    logic [RW-1:0]  r_hit_row;
    logic           r_ovf;

    logic           r_o_found;
    logic [6:0]     r_o_pos;
    logic           r_o_sfound;
    logic [7:0]     r_o_row;
    logic           r_o_ovf;

    logic           w_match;
    logic           w_active;
    logic           w_hit;
    logic           w_found;
    logic           w_pat_room;
    logic [31:0]    w_pos32;
    logic [RW-1:0]  w_row_inc;
    logic [RW-1:0]  n_hit_row;
    logic [31:0]    w_row32;

    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((PATTERN_MAX - i) <= int'(r_plen)) begin
                if (r_pat[i] != r_win[i] && r_pat[i] != wss_pkg::WILDCARD &&
                    r_win[i] != wss_pkg::WILDCARD) begin
                    w_match = 1'b0;
                end
            end
        end
    end

    assign w_pat_room = 32'(r_plen) < 32'(PATTERN_MAX);
    assign w_active   = !r_search_hit && (32'(r_row) < 32'(ROWS_MAX));
    assign w_hit      = w_active && !r_line_hit && (r_plen != '0) &&
                        (32'(r_col) >= 32'(r_plen)) && w_match;
    assign w_found    = w_active && ((r_plen == '0) ? (r_col != '0) : r_line_hit);
    assign w_pos32    = (w_active && r_plen != '0 && r_line_hit) ? 32'(r_hit_col) : 32'd0;
    assign w_row_inc  = RW'(32'(r_row) + 32'd1);
    assign n_hit_row  = w_found ? w_row_inc : r_hit_row;
    assign w_row32    = 32'(n_hit_row);

    assign o_status.text_room = 32'(r_col) < 32'(LINE_MAX - 1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pat_push && w_pat_room) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_pat[i] <= r_pat[i + 1];
            end
            r_pat[PATTERN_MAX - 1] <= i_data_byte;
        end
        if (i_cmd.text_push) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[PATTERN_MAX - 1] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_line_hit   <= 1'b0;
            r_hit_col    <= '0;
            r_search_hit <= 1'b0;
            r_hit_row    <= '0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.clear) begin
            r_plen       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_line_hit   <= 1'b0;
            r_hit_col    <= '0;
            r_search_hit <= 1'b0;
            r_hit_row    <= '0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.eol) begin
            if (w_active) begin
                r_row <= w_row_inc;
            end
            if (w_found) begin
                r_search_hit <= 1'b1;
            end
            r_hit_row  <= n_hit_row;
            r_col      <= '0;
            r_line_hit <= 1'b0;
            r_hit_col  <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cmd.pat_push && w_pat_room) begin
                r_plen <= r_plen + 1'b1;
            end
            if (i_cmd.text_push) begin
                r_col <= r_col + 1'b1;
            end
            if (i_cmd.text_drop) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.check && w_hit) begin
                r_line_hit <= 1'b1;
                r_hit_col  <= CW'(32'(r_col) - 32'(r_plen));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eol) begin
            r_o_found  <= w_found;
            r_o_pos    <= w_pos32[6:0];
            r_o_sfound <= r_search_hit | w_found;
            r_o_row    <= w_row32[7:0];
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_line_found    = r_o_found;
    assign o_line_position = r_o_pos;
    assign o_search_found  = r_o_sfound;
    assign o_found_row     = r_o_row;
    assign o_line_overflow = r_o_ovf;

    `ASSERT_IMPL(a_hit_needs_pattern, r_line_hit, (r_plen != '0) && (r_hit_col < r_col),
        "line hit without a pattern or past the kept bytes")
    `ASSERT_IMPL(a_search_hit_row, r_search_hit, (r_hit_row != '0) && (r_hit_row <= r_row),
        "search hit with an invalid row")

endmodule

`default_nettype wire

### design/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// Controller: decodes accepted transactions into datapath commands, runs the
// compare cycle after each kept text byte, owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_action,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire wss_pkg::t_status  i_status,
    output wss_pkg::t_cmd          o_cmd
);

    wss_pkg::t_state r_state;
    wss_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wss_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wss_pkg::S_IDLE: begin
                if (w_accept && i_action == wss_pkg::ACT_TEXT && i_status.text_room) begin
                    n_state = wss_pkg::S_CHECK;
                end
            end
            wss_pkg::S_CHECK: begin
                n_state = wss_pkg::S_IDLE;
            end
            default: begin
                n_state = wss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state == wss_pkg::S_CHECK) ||
                     (i_action == wss_pkg::ACT_EOL && r_out_valid && i_out_stall);
        case (r_state)
            wss_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (wss_pkg::t_action'(i_action))
                        wss_pkg::ACT_PATTERN: o_cmd.pat_push = 1'b1;
                        wss_pkg::ACT_TEXT: begin
                            o_cmd.text_push = i_status.text_room;
                            o_cmd.text_drop = !i_status.text_room;
                        end
                        wss_pkg::ACT_EOL: o_cmd.eol   = 1'b1;
                        wss_pkg::ACT_NEW: o_cmd.clear = 1'b1;
                        default: o_cmd = '0;
                    endcase
                end
            end
            wss_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.eol || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_cmd_onehot, $onehot0(o_cmd), "more than one datapath command")
    `ASSERT_IMPL(a_check_follows_text, r_state == wss_pkg::S_CHECK, $past(o_cmd.text_push),
        "compare cycle without a kept text byte")
    `ASSERT_IMPL(a_no_result_overrun, o_cmd.eol, !r_out_valid || !i_out_stall,
        "end of line taken while result register is held")

endmodule

`default_nettype wire

### design/wildcard_substring_search.sv
// ----------------------------------------------------------------------------
// wildcard_substring_search
// Pattern byte, dropped text byte and new search: taken without a compare state.
// Kept text byte: shift into the window, then the full-width compare in the check state.
// End of line: stalled while the previous result is still held or a compare runs.
// Result is valid the cycle after the end-of-line transaction, one per line.
// Reset (sync, active low) clears control state; byte stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_substring_search #(
    parameter int PATTERN_MAX = 64,
    parameter int LINE_MAX    = 128,
    parameter int ROWS_MAX    = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_line_found,
    output logic [6:0]       o_line_position,
    output logic             o_search_found,
    output logic [7:0]       o_found_row,
    output logic             o_line_overflow
);

    wss_pkg::t_cmd    w_cmd;
    wss_pkg::t_status w_status;

    wss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_action    (i_action),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wss_dp #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_MAX    (LINE_MAX),
        .ROWS_MAX    (ROWS_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_data_byte),
        .o_status        (w_status),
        .o_line_found    (o_line_found),
        .o_line_position (o_line_position),
        .o_search_found  (o_search_found),
        .o_found_row     (o_found_row),
        .o_line_overflow (o_line_overflow)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_substring_search testbench
// Drives pattern, text, end-of-line and new-search transactions through the
// block and checks every per-line result against a behavioral search model
// kept in the testbench. Directed cases come first, then random searches
// under four sender/receiver idling mixes, with more directed cases between them.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int PATTERN_MAX = 64;
    localparam int LINE_MAX    = 128;
    localparam int ROWS_MAX    = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 220;

    typedef struct {
        wss_pkg::t_action act;
        logic [7:0]       data;
    } t_xact;

    typedef struct {
        logic       found;
        logic [6:0] position;
        logic       search_found;
        logic [7:0] row;
        logic       overflow;
    } t_line_result;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    wss_pkg::t_action i_action    = wss_pkg::ACT_PATTERN;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_line_found;
    logic [6:0] o_line_position;
    logic       o_search_found;
    logic [7:0] o_found_row;
    logic       o_line_overflow;

    wildcard_substring_search #(
        .PATTERN_MAX(PATTERN_MAX),
        .LINE_MAX(LINE_MAX),
        .ROWS_MAX(ROWS_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_action(i_action),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_line_found(o_line_found),
        .o_line_position(o_line_position),
        .o_search_found(o_search_found),
        .o_found_row(o_found_row),
        .o_line_overflow(o_line_overflow)
    );

    always #6 i_clk = ~i_clk;

    t_xact        pending_xacts[$];
    t_line_result expected_lines[$];
    int n_queued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int cycles     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // search state
    logic [7:0] pattern_bytes[PATTERN_MAX];
    logic [7:0] text_tail[PATTERN_MAX];
    int   pattern_len  = 0;
    int   line_cols    = 0;
    int   rows_done    = 0;
    logic line_match   = 1'b0;
    int   match_col    = 0;
    logic search_done  = 1'b0;
    int   match_row    = 0;
    logic line_dropped = 1'b0;

    task automatic clear_line_state();
        line_cols    = 0;
        line_match   = 1'b0;
        match_col    = 0;
        line_dropped = 1'b0;
    endtask

    task automatic search_step(input wss_pkg::t_action act, input logic [7:0] b);
        t_line_result r;
        logic hit;
        logic found;
        int   pos;
        int   base;
        int   k;
        case (act)
            wss_pkg::ACT_PATTERN: begin
                if (pattern_len < PATTERN_MAX) begin
                    pattern_bytes[pattern_len] = b;
                    pattern_len++;
                end
            end
            wss_pkg::ACT_TEXT: begin
                if (line_cols >= LINE_MAX - 1) begin
                    line_dropped = 1'b1;
                end else begin
                    for (k = 0; k < PATTERN_MAX - 1; k++) text_tail[k] = text_tail[k + 1];
                    text_tail[PATTERN_MAX - 1] = b;
                    line_cols++;
                    if (!search_done && rows_done < ROWS_MAX && !line_match &&
                        pattern_len > 0 && line_cols >= pattern_len) begin
                        hit  = 1'b1;
                        base = PATTERN_MAX - pattern_len;
                        for (k = 0; k < pattern_len; k++) begin
                            if (pattern_bytes[k] != text_tail[base + k] &&
                                pattern_bytes[k] != wss_pkg::WILDCARD &&
                                text_tail[base + k] != wss_pkg::WILDCARD)
                                hit = 1'b0;
                        end
                        if (hit) begin
                            line_match = 1'b1;
                            match_col  = line_cols - pattern_len;
                        end
                    end
                end
            end
            wss_pkg::ACT_EOL: begin
                found = 1'b0;
                pos   = 0;
                if (!search_done && rows_done < ROWS_MAX) begin
                    if (pattern_len == 0) begin
                        found = (line_cols > 0);
                    end else if (line_match) begin
                        found = 1'b1;
                        pos   = match_col;
                    end
                    rows_done++;
                    if (found) begin
                        search_done = 1'b1;
                        match_row   = rows_done;
                    end
                end
                r.found        = found;
                r.position     = pos[6:0];
                r.search_found = search_done;
                r.row          = match_row[7:0];
                r.overflow     = line_dropped;
                expected_lines.push_back(r);
                clear_line_state();
            end
            default: begin
                pattern_len = 0;
                clear_line_state();
                rows_done   = 0;
                search_done = 1'b0;
                match_row   = 0;
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_xact x;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                search_step(i_action, i_data_byte);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_xacts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    x = pending_xacts.pop_front();
                    i_valid     <= 1'b1;
                    i_action    <= x.act;
                    i_data_byte <= x.data;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_line_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_lines.size() == 0) begin
                    if (n_errors < 10)
                        $display("unexpected result: found=%0d pos=%0d sfound=%0d row=%0d ovf=%0d",
                                 o_line_found, o_line_position, o_search_found, o_found_row,
                                 o_line_overflow);
                    n_errors++;
                end else begin
                    e = expected_lines.pop_front();
                    if (o_line_found !== e.found || o_line_position !== e.position ||
                        o_search_found !== e.search_found || o_found_row !== e.row ||
                        o_line_overflow !== e.overflow) begin
                        if (n_errors < 10) begin
                            $display("mismatch: exp found=%0d pos=%0d sfound=%0d row=%0d ovf=%0d",
                                     e.found, e.position, e.search_found, e.row, e.overflow);
                            $display("          got found=%0d pos=%0d sfound=%0d row=%0d ovf=%0d",
                                     o_line_found, o_line_position, o_search_found,
                                     o_found_row, o_line_overflow);
                        end
                        n_errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic add(input wss_pkg::t_action act, input logic [7:0] b);
        t_xact x;
        x.act  = act;
        x.data = b;
        pending_xacts.push_back(x);
        n_queued++;
    endtask

    task automatic add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) add(wss_pkg::ACT_TEXT, s[k]);
    endtask

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(99);
        if (r < 60) return (r[0] ? "a" : "b");
        if (r < 70) return wss_pkg::WILDCARD;
        return 8'($urandom_range(255));
    endfunction

    task automatic gen_search();
        logic [7:0] pat[PATTERN_MAX + 8];
        int plen;
        int nlines;
        int n;
        int k;
        int j;
        int r;
        if ($urandom_range(99) >= 3) add(wss_pkg::ACT_NEW, 8'($urandom));
        r = $urandom_range(99);
        if (r < 10)      plen = 0;
        else if (r < 80) plen = $urandom_range(1, 4);
        else if (r < 95) plen = $urandom_range(5, 10);
        else             plen = $urandom_range(60, 68);
        for (k = 0; k < plen; k++) begin
            pat[k] = rand_char();
            add(wss_pkg::ACT_PATTERN, pat[k]);
        end
        nlines = ($urandom_range(99) < 90) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        for (j = 0; j < nlines; j++) begin
            r = $urandom_range(99);
            if (r < 85)      n = $urandom_range(0, 10);
            else if (r < 95) n = $urandom_range(11, 40);
            else             n = $urandom_range(120, 130);
            for (k = 0; k < n; k++) begin
                add(wss_pkg::ACT_TEXT, rand_char());
                if ($urandom_range(199) == 0) add(wss_pkg::ACT_PATTERN, rand_char());
            end
            if ($urandom_range(99) < 30) begin
                for (k = 0; k < plen && k < PATTERN_MAX; k++) add(wss_pkg::ACT_TEXT, pat[k]);
                for (k = 0; k < n % 4; k++) add(wss_pkg::ACT_TEXT, rand_char());
            end
            add(wss_pkg::ACT_EOL, 8'($urandom));
        end
    endtask

    // many empty lines: a hit on the last examined row, or one past the limit
    task automatic gen_row_limit(input logic hit_last);
        int k;
        add(wss_pkg::ACT_NEW, 8'($urandom));
        add(wss_pkg::ACT_PATTERN, "z");
        for (k = 0; k < ROWS_MAX - 1; k++) add(wss_pkg::ACT_EOL, 8'($urandom));
        if (!hit_last) add(wss_pkg::ACT_EOL, 8'($urandom));
        add(wss_pkg::ACT_TEXT, "z");
        add(wss_pkg::ACT_EOL, 8'($urandom));
        add(wss_pkg::ACT_EOL, 8'($urandom));
    endtask

    // match at the last kept column, then dropped bytes
    task automatic gen_wide_line();
        int k;
        add(wss_pkg::ACT_NEW, 8'($urandom));
        add(wss_pkg::ACT_PATTERN, "q");
        for (k = 0; k < LINE_MAX - 2; k++) add(wss_pkg::ACT_TEXT, "a");
        add(wss_pkg::ACT_TEXT, "q");
        for (k = 0; k < 3; k++) add(wss_pkg::ACT_TEXT, 8'($urandom));
        add(wss_pkg::ACT_EOL, 8'($urandom));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        stop_at        = n_queued + PHASE_ITEMS;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n_queued < stop_at) gen_search();
        while (n_accepted != n_queued) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty pattern: empty line misses, non-empty line hits at column 0
        add(wss_pkg::ACT_EOL, 8'hFF);
        add(wss_pkg::ACT_TEXT, 8'h00);
        add(wss_pkg::ACT_EOL, 8'h00);
        add_text("x");
        add(wss_pkg::ACT_EOL, 8'h5A);
        // extreme bytes and wildcard on both sides
        add(wss_pkg::ACT_NEW, 8'hFF);
        add(wss_pkg::ACT_PATTERN, 8'h00);
        add(wss_pkg::ACT_PATTERN, wss_pkg::WILDCARD);
        add(wss_pkg::ACT_PATTERN, 8'hFF);
        add(wss_pkg::ACT_TEXT, "a");
        add(wss_pkg::ACT_TEXT, 8'h00);
        add(wss_pkg::ACT_TEXT, "q");
        add(wss_pkg::ACT_TEXT, wss_pkg::WILDCARD);
        add(wss_pkg::ACT_EOL, 8'hAA);
        // pattern grows in the middle of a line
        add(wss_pkg::ACT_NEW, 8'h00);
        add(wss_pkg::ACT_PATTERN, "b");
        add(wss_pkg::ACT_TEXT, "a");
        add(wss_pkg::ACT_PATTERN, "c");
        add_text("bc");
        add(wss_pkg::ACT_EOL, 8'h55);
        add(wss_pkg::ACT_TEXT, 8'hFF);
        add(wss_pkg::ACT_EOL, 8'h3F);
        while (n_accepted != n_queued) @(posedge i_clk);

        gen_row_limit(1'b1);
        run_phase(0, 0);
        while (expected_lines.size() != 0) @(posedge i_clk);
        gen_wide_line();
        run_phase(85, 0);
        run_phase(0, 85);
        gen_row_limit(1'b0);
        run_phase(20, 20);

        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_errors == 0 && expected_lines.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
